### hw/rtl/slb_pkg.sv
// Shared types, codes and lookup tables of the sprite layer blitter.
package slb_pkg;

  // Default layer dimensions in pixels.
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;

  // Configuration register widths and reset values.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned DIM_CMP_W  = DIM_W + 1;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 10'd512;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 10'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RED    = 3'd2,
    CFG_GREEN  = 3'd3,
    CFG_BLUE   = 3'd4
  } slb_cfg_e;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_BLIT  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } slb_mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } slb_state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        on_foreground;
    logic [3:0]  blend_color;
    logic        flip_x;
    logic        flip_y;
    logic        two_bits_per_pixel;
    logic [63:0] plane_low;
    logic [63:0] plane_high;
  } slb_in_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        foreground_changed;
    logic        background_changed;
  } slb_out_t;

  // Blend result indexed by [sprite color][blend mode].
  localparam logic [1:0] BLEND_LUT [4][16] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
      2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
      2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
  };

  // Bit n set: blend mode n draws color 0 pixels too.
  localparam logic [15:0] OPAQUE_MASK = 16'h7BDF;

  function automatic logic [1:0] blend_value(input logic [1:0] color, input logic [3:0] blend);
    return BLEND_LUT[color][blend];
  endfunction

  // Palette nibble of a color, color 0 in the top nibble, doubled to 8 bits.
  function automatic logic [7:0] level_byte(input logic [15:0] levels, input logic [1:0] color);
    logic [3:0] nib;
    nib = levels[{~color, 2'b00} +: 4];
    return {nib, nib};
  endfunction

endpackage

### hw/rtl/slb_if.sv
// Valid/ready item channels of the sprite layer blitter.
interface slb_in_if;
  logic             valid;
  logic             ready;
  slb_pkg::slb_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slb_out_if;
  logic              valid;
  logic              ready;
  slb_pkg::slb_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/sprite_layer_blitter_core.sv
// Two-layer 2-bit framebuffer with pixel write, 8x8 sprite blit and composited read.
// Usage:
//   in_i carries one command item: a pixel write, a sprite blit, a composited
//   pixel read or a no-op. out_o returns exactly one result item per command:
//   the palette color for a read (zero otherwise) and both layer changed flags.
//   The plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) sets screen size and
//   the palette levels; write it only while no command is in flight.
// Flow:
//   One command at a time; each framebuffer pixel passes the shared address
//   multiplier, then the read, then the compare and write of the memory port.
//   Off-screen and undrawn sprite pixels skip the read and write; a no-op goes
//   straight to its result, and a blit visits all 64 sprite pixels.
// Reset:
//   Reset clears flags, counters and palette levels and loads the reset screen
//   size, then a clearing pass zeroes both layers, one location per cycle;
//   in_i.ready stays low meanwhile, configuration writes are still taken.
// Stalls:
//   A finished result waits in the output register; the next command is
//   accepted meanwhile and holds in its last state until out_o frees up.
module sprite_layer_blitter_core #(
  parameter int unsigned MAX_WIDTH  = slb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = slb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  slb_in_if.sink                         in_i,
  slb_out_if.source                      out_o
);
  import slb_pkg::*;

  localparam int unsigned LAYER_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = $clog2(LAYER_SIZE);
  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = YW + EW;
  localparam logic [AW-1:0] CLR_LAST = AW'(LAYER_SIZE - 1);

  // Configuration registers.
  logic [DIM_W-1:0] width_q, height_q;
  logic [15:0]      red_q, green_q, blue_q;

  // Control state.
  slb_state_e  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [AW-1:0] clr_cnt_q;
  logic        fg_dirty_q, fg_dirty_d;
  logic        bg_dirty_q, bg_dirty_d;
  logic        out_valid_q;
  slb_out_t    out_data_q;

  // Item registers.
  slb_mode_e   mode_q;
  logic [15:0] x_q, y_q;
  logic        fg_q;
  logic [3:0]  blend_q;
  logic        fx_q, fy_q;
  logic [63:0] plane_lo_q, plane_hi_q;

  // Per-pixel datapath registers.
  logic [AW-1:0] prod_q;
  logic [XW-1:0] px_q;
  logic [1:0]    val_q;
  logic [1:0]    col_q;
  logic [AW-1:0] addr_q;
  logic [3:0]    rd_q;

  // Layer memory: foreground in [3:2], background in [1:0].
  logic [3:0] layer_mem_q [LAYER_SIZE];

  // Saturate screen size to the layer dimensions.
  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;

  always_comb begin
    if ({1'b0, width_q} > DIM_CMP_W'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
    if ({1'b0, height_q} > DIM_CMP_W'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(height_q);
    end
  end

  // Current pixel: coordinates, value to store and whether to draw it.
  logic [2:0]  row_v, col_b, row_off, col_off;
  logic [5:0]  bit_idx;
  logic [1:0]  sprite_ch;
  logic [15:0] px, py;
  logic [1:0]  pix_val;
  logic        pix_draw;
  logic        pix_inb;
  logic [PW-1:0] prod_full;

  always_comb begin
    row_v     = cnt_q[5:3];
    col_b     = cnt_q[2:0];
    row_off   = fy_q ? ~row_v : row_v;
    col_off   = fx_q ? col_b : ~col_b;
    // Row 0 sits in the top byte, pixel 0 of a row in its top bit.
    bit_idx   = {~row_v, col_b};
    sprite_ch = {plane_hi_q[bit_idx], plane_lo_q[bit_idx]};
    if (mode_q == MODE_BLIT) begin
      px       = x_q + {13'd0, col_off};
      py       = y_q + {13'd0, row_off};
      pix_val  = blend_value(sprite_ch, blend_q);
      pix_draw = OPAQUE_MASK[blend_q] || (sprite_ch != 2'd0);
    end else begin
      px       = x_q;
      py       = y_q;
      pix_val  = blend_q[1:0];
      pix_draw = 1'b1;
    end
    pix_inb   = (px < 16'(eff_w)) && (py < 16'(eff_h));
    prod_full = PW'(py[YW-1:0]) * PW'(eff_w);
  end

  logic          blit_more;
  logic [AW-1:0] rd_addr;
  logic [1:0]    old_pix;
  logic          pix_changed;

  assign blit_more   = (mode_q == MODE_BLIT) && !(&cnt_q);
  assign rd_addr     = prod_q + AW'(px_q);
  assign old_pix     = fg_q ? rd_q[3:2] : rd_q[1:0];
  assign pix_changed = old_pix != val_q;

  // Next state.
  logic load_out;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          if (slb_mode_e'(in_i.payload.mode) == MODE_NOP) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        if (pix_draw && pix_inb) begin
          state_d = ST_READ;
        end else if (blit_more) begin
          state_d = ST_ADDR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_READ: state_d = ST_WRITE;
      ST_WRITE: begin
        state_d = blit_more ? ST_ADDR : ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory write, flags, pixel counter.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [3:0]    mem_wdata;
  logic          clear_flags;
  logic          level_write;

  assign level_write = cfg_we_i && (cfg_idx_i inside {CFG_RED, CFG_GREEN, CFG_BLUE});
  assign clear_flags = load_out && (mode_q == MODE_READ);

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = fg_q ? {val_q, rd_q[1:0]} : {rd_q[3:2], val_q};
    fg_dirty_d = fg_dirty_q;
    bg_dirty_d = bg_dirty_q;
    cnt_d      = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 4'd0;
      end
      ST_IDLE: begin
        cnt_d = 6'd0;
      end
      ST_ADDR: begin
        if (!(pix_draw && pix_inb) && blit_more) cnt_d = cnt_q + 6'd1;
      end
      ST_WRITE: begin
        if (mode_q != MODE_READ && pix_changed) begin
          mem_we = 1'b1;
          if (fg_q) begin
            fg_dirty_d = 1'b1;
          end else begin
            bg_dirty_d = 1'b1;
          end
        end
        if (blit_more) cnt_d = cnt_q + 6'd1;
      end
      default: ;
    endcase
    if (level_write) begin
      fg_dirty_d = 1'b1;
      bg_dirty_d = 1'b1;
    end
    // Report the flags, then drop them, on a read.
    if (clear_flags) begin
      fg_dirty_d = 1'b0;
      bg_dirty_d = 1'b0;
    end
  end

  // Result item.
  slb_out_t out_d;

  always_comb begin
    out_d.pixel_rgb          = '0;
    out_d.foreground_changed = fg_dirty_q;
    out_d.background_changed = bg_dirty_q;
    if (mode_q == MODE_READ) begin
      out_d.pixel_rgb = {level_byte(red_q, col_q), level_byte(green_q, col_q),
                         level_byte(blue_q, col_q)};
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_cnt_q   <= '0;
      fg_dirty_q  <= 1'b0;
      bg_dirty_q  <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fg_dirty_q <= fg_dirty_d;
      bg_dirty_q <= bg_dirty_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
          CFG_RED:    red_q    <= cfg_data_i;
          CFG_GREEN:  green_q  <= cfg_data_i;
          CFG_BLUE:   blue_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Item and datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      mode_q     <= slb_mode_e'(in_i.payload.mode);
      x_q        <= in_i.payload.pos_x;
      y_q        <= in_i.payload.pos_y;
      fg_q       <= in_i.payload.on_foreground;
      blend_q    <= in_i.payload.blend_color;
      fx_q       <= in_i.payload.flip_x;
      fy_q       <= in_i.payload.flip_y;
      plane_lo_q <= in_i.payload.plane_low;
      // One bit per pixel: the high plane reads as zero.
      plane_hi_q <= in_i.payload.two_bits_per_pixel ? in_i.payload.plane_high : 64'd0;
    end
    if (state_q == ST_ADDR) begin
      prod_q <= AW'(prod_full);
      px_q   <= px[XW-1:0];
      val_q  <= pix_val;
      // Outside the screen a read sees color 0.
      col_q  <= 2'd0;
    end
    if (state_q == ST_WRITE) begin
      // Nonzero foreground wins over background.
      col_q <= (rd_q[3:2] != 2'd0) ? rd_q[3:2] : rd_q[1:0];
    end
    if (state_q == ST_READ) addr_q <= rd_addr;
    if (load_out) out_data_q <= out_d;
  end

  // Layer memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) layer_mem_q[mem_waddr] <= mem_wdata;
    rd_q <= layer_mem_q[rd_addr];
  end

  assign in_i.ready    = state_q == ST_IDLE;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

`ifndef SYNTHESIS
  // Outside the clearing pass, the memory is written only where a pixel changes.
  a_write_only_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != ST_CLEAR) |-> (state_q == ST_WRITE && pix_changed))
    else $error("layer written without a change of value");

  // A read result drops both changed flags.
  a_read_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clear_flags && !cfg_we_i) |=> (!fg_dirty_q && !bg_dirty_q))
    else $error("changed flags survive a read");

  // Only a blit walks the sprite pixel counter.
  a_cnt_blit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR && mode_q != MODE_BLIT) |-> (cnt_q == 6'd0))
    else $error("pixel counter moved outside a blit");

  // A finished command holds while the output register is occupied.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_o.ready) |=> (state_q == ST_DONE))
    else $error("result left before the output register freed up");
`endif

endmodule

### tb/sv/sprite_layer_blitter_core_test.sv
// Self-checking test of the sprite layer blitter against a shadow copy of both layers.
module sprite_layer_blitter_core_test;
  import slb_pkg::*;

  localparam int unsigned LAYER_PIXELS   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  // Clearing pass plus 400+ items at the slowest blit and heavy stalls fits many times over.
  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  localparam int unsigned PRINT_CAP      = 100;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned PHASES         = 8;

  // Shadow framebuffer: tracks both layers, the changed flags and the register file,
  // and holds the results the block still owes, oldest first.
  class framebuffer_shadow;
    bit [1:0]    fg_px [LAYER_PIXELS];
    bit [1:0]    bg_px [LAYER_PIXELS];
    bit          fg_dirty;
    bit          bg_dirty;
    bit [9:0]    width_reg;
    bit [9:0]    height_reg;
    bit [15:0]   red_lv;
    bit [15:0]   green_lv;
    bit [15:0]   blue_lv;
    slb_out_t    owed[$];
    int unsigned mismatches;
    int unsigned replies_ok;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    function void set_register(slb_cfg_e idx, bit [15:0] data);
      case (idx)
        CFG_WIDTH:  width_reg = data[9:0];
        CFG_HEIGHT: height_reg = data[9:0];
        CFG_RED:    begin
          red_lv = data;
          {fg_dirty, bg_dirty} = 2'b11;
        end
        CFG_GREEN:  begin
          green_lv = data;
          {fg_dirty, bg_dirty} = 2'b11;
        end
        CFG_BLUE:   begin
          blue_lv = data;
          {fg_dirty, bg_dirty} = 2'b11;
        end
        default: ;
      endcase
    endfunction

    function int unsigned span(bit [9:0] r, int unsigned cap);
      return (r > cap) ? cap : r;
    endfunction

    function void store_pixel(bit fg, bit [15:0] x, bit [15:0] y, bit [1:0] v);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      w = span(width_reg, MAX_WIDTH_DEF);
      h = span(height_reg, MAX_HEIGHT_DEF);
      if (x >= w || y >= h) return;
      idx = x + y * w;
      if (fg) begin
        if (fg_px[idx] != v) begin
          fg_px[idx] = v;
          fg_dirty = 1'b1;
        end
      end else begin
        if (bg_px[idx] != v) begin
          bg_px[idx] = v;
          bg_dirty = 1'b1;
        end
      end
    endfunction

    // Blend rule per sprite color, written out from the pattern of the blend table.
    function bit [1:0] blended(bit [1:0] color, bit [3:0] m);
      case (color)
        2'd0:    return (m[1:0] == m[3:2]) ? 2'd0 : m[3:2];
        2'd1:    return m[1:0];
        2'd2:    return (m[1:0] == 2'd3) ? 2'd1 : m[1:0] + 2'd1;
        default: return (m[1:0] < 2'd2) ? m[1:0] + 2'd2 : m[1:0] - 2'd1;
      endcase
    endfunction

    function void stamp_sprite(slb_in_t c);
      bit [7:0]  lo_row;
      bit [7:0]  hi_row;
      bit [1:0]  color;
      bit [15:0] px;
      bit [15:0] py;
      bit        draws_zero;
      int        row;
      int        col;
      // A blend mode with matching halves (other than 0) leaves color 0 transparent.
      draws_zero = !(c.blend_color[1:0] == c.blend_color[3:2] && c.blend_color[1:0] != 2'd0);
      for (row = 0; row < 8; row++) begin
        lo_row = c.plane_low[56 - 8 * row +: 8];
        hi_row = c.two_bits_per_pixel ? c.plane_high[56 - 8 * row +: 8] : 8'h00;
        py = 16'(c.pos_y + (c.flip_y ? 7 - row : row));
        for (col = 0; col < 8; col++) begin
          color = {hi_row[col], lo_row[col]};
          px = 16'(c.pos_x + (c.flip_x ? col : 7 - col));
          if (draws_zero || color != 2'd0)
            store_pixel(c.on_foreground, px, py, blended(color, c.blend_color));
        end
      end
    endfunction

    function bit [23:0] composite_rgb(bit [15:0] x, bit [15:0] y);
      bit [1:0]    f;
      bit [1:0]    b;
      bit [1:0]    c;
      bit [7:0]    r8;
      bit [7:0]    g8;
      bit [7:0]    b8;
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      int          sh;
      f = 2'd0;
      b = 2'd0;
      w = span(width_reg, MAX_WIDTH_DEF);
      h = span(height_reg, MAX_HEIGHT_DEF);
      if (x < w && y < h) begin
        idx = x + y * w;
        f = fg_px[idx];
        b = bg_px[idx];
      end
      c = (f != 2'd0) ? f : b;
      sh = 12 - 4 * c;
      r8 = 8'h11 * red_lv[sh +: 4];
      g8 = 8'h11 * green_lv[sh +: 4];
      b8 = 8'h11 * blue_lv[sh +: 4];
      return {r8, g8, b8};
    endfunction

    function void take_command(slb_in_t c);
      slb_out_t r;
      r = '0;
      case (c.mode)
        MODE_WRITE: store_pixel(c.on_foreground, c.pos_x, c.pos_y, c.blend_color[1:0]);
        MODE_BLIT:  stamp_sprite(c);
        MODE_READ:  r.pixel_rgb = composite_rgb(c.pos_x, c.pos_y);
        default: ;
      endcase
      r.foreground_changed = fg_dirty;
      r.background_changed = bg_dirty;
      if (c.mode == MODE_READ) {fg_dirty, bg_dirty} = 2'b00;
      owed.push_back(r);
    endfunction

    task match_reply(slb_out_t got);
      slb_out_t want;
      bit       clean;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, rgb %h", got.pixel_rgb));
        return;
      end
      want = owed.pop_front();
      clean = 1'b1;
      if (got.pixel_rgb !== want.pixel_rgb) begin
        clean = 1'b0;
        report_mismatch($sformatf("pixel_rgb %h, want %h", got.pixel_rgb, want.pixel_rgb));
      end
      if (got.foreground_changed !== want.foreground_changed) begin
        clean = 1'b0;
        report_mismatch($sformatf("foreground_changed %b, want %b",
                                  got.foreground_changed, want.foreground_changed));
      end
      if (got.background_changed !== want.background_changed) begin
        clean = 1'b0;
        report_mismatch($sformatf("background_changed %b, want %b",
                                  got.background_changed, want.background_changed));
      end
      if (clean) replies_ok++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  slb_in_if  cmd_if ();
  slb_out_if res_if ();

  sprite_layer_blitter_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  framebuffer_shadow shadow;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       mode_count [4];
  int unsigned       settings_seen;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Observe every handshake at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_we) shadow.set_register(slb_cfg_e'(cfg_idx), cfg_data);
      if (cmd_if.valid && cmd_if.ready) begin
        shadow.take_command(cmd_if.payload);
        mode_count[cmd_if.payload.mode]++;
      end
      if (res_if.valid && res_if.ready) shadow.match_reply(res_if.payload);
    end
  end

  // Receiver: stall at random at the phase's rate, one decision per cycle.
  always @(posedge clk) res_if.ready <= ($urandom_range(99) >= stall_pct);

  // Hold the item until the block takes it; idle first for a random gap.
  task automatic send_command(slb_in_t c);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (shadow.owed.size() != 0) @(posedge clk);
  endtask

  // Write the screen size and, when asked, the three palette registers.
  // Call only while the block is idle.
  task automatic program_screen(bit [15:0] w, bit [15:0] h, bit with_palette,
                                bit [15:0] red, bit [15:0] green, bit [15:0] blue);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    if (with_palette) begin
      cfg_idx  <= CFG_RED;
      cfg_data <= red;
      @(posedge clk);
      cfg_idx  <= CFG_GREEN;
      cfg_data <= green;
      @(posedge clk);
      cfg_idx  <= CFG_BLUE;
      cfg_data <= blue;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  function automatic slb_in_t make_cmd(slb_mode_e mode, bit [15:0] x, bit [15:0] y,
                                       bit fg = 1'b0, bit [3:0] blend = 4'h0,
                                       bit fx = 1'b0, bit fy = 1'b0, bit two = 1'b0,
                                       bit [63:0] lo = '0, bit [63:0] hi = '0);
    slb_in_t c;
    c.mode               = mode;
    c.pos_x              = x;
    c.pos_y              = y;
    c.on_foreground      = fg;
    c.blend_color        = blend;
    c.flip_x             = fx;
    c.flip_y             = fy;
    c.two_bits_per_pixel = two;
    c.plane_low          = lo;
    c.plane_high         = hi;
    return c;
  endfunction

  // Aim most coordinates at a small corner so reads land on drawn pixels;
  // the rest go anywhere, near the far edge, or just below the 16-bit wrap.
  function automatic bit [15:0] pick_coord(int unsigned extent);
    int unsigned near;
    near = (extent > 40) ? 40 : extent;
    case ($urandom_range(19))
      0, 1:    return 16'($urandom());
      2:       return 16'hFFFF - 16'($urandom_range(7));
      3, 4:    return 16'(extent + $urandom_range(3)) - 16'd2;
      default: return 16'($urandom_range(near));
    endcase
  endfunction

  function automatic slb_in_t random_cmd(int unsigned extent_x, int unsigned extent_y);
    slb_in_t   c;
    bit [63:0] lo;
    bit [63:0] hi;
    int unsigned pick;
    slb_mode_e mode;
    pick = $urandom_range(19);
    if (pick < 7)       mode = MODE_WRITE;
    else if (pick < 13) mode = MODE_BLIT;
    else if (pick < 19) mode = MODE_READ;
    else                mode = MODE_NOP;
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    // Thin out the planes now and then so transparent pixels show up in bulk.
    if ($urandom_range(2) == 0) lo &= {$urandom(), $urandom()};
    if ($urandom_range(2) == 0) hi &= {$urandom(), $urandom()};
    c = make_cmd(mode, pick_coord(extent_x), pick_coord(extent_y), 1'($urandom()),
                 4'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()), lo, hi);
    return c;
  endfunction

  // Fixed cases: corners, off-screen writes, repeated values, every blend family,
  // flips, wrapping origins, zero and saturated screen sizes, the unused mode.
  task automatic run_directed();
    program_screen(16'd16, 16'd8, 1'b1, 16'h0F84, 16'h09C3, 16'hE52A);
    send_command(make_cmd(MODE_READ, 0, 0));
    send_command(make_cmd(MODE_WRITE, 0, 0, 1'b1, 4'h3));
    send_command(make_cmd(MODE_WRITE, 1, 0, 1'b0, 4'hE));
    send_command(make_cmd(MODE_READ, 0, 0));
    send_command(make_cmd(MODE_READ, 1, 0));
    // Same value again must leave the changed flags alone.
    send_command(make_cmd(MODE_WRITE, 1, 0, 1'b0, 4'h2));
    send_command(make_cmd(MODE_READ, 1, 0));
    send_command(make_cmd(MODE_WRITE, 15, 7, 1'b1, 4'hF));
    send_command(make_cmd(MODE_WRITE, 16, 0, 1'b1, 4'h1));
    send_command(make_cmd(MODE_WRITE, 0, 8, 1'b0, 4'h1));
    send_command(make_cmd(MODE_WRITE, 16'hFFFF, 16'hFFFF, 1'b1, 4'h2));
    send_command(make_cmd(MODE_READ, 15, 7));
    send_command(make_cmd(MODE_READ, 16'hFFFF, 0));
    send_command(make_cmd(MODE_BLIT, 2, 1, 1'b0, 4'h1, 1'b0, 1'b0, 1'b0,
                          64'h8142_2418_1824_4281, 64'hFFFF_FFFF_FFFF_FFFF));
    send_command(make_cmd(MODE_BLIT, 6, 0, 1'b1, 4'h5, 1'b1, 1'b0, 1'b1,
                          64'hF0F0_CCCC_AAAA_0F0F, 64'h00FF_3C3C_5555_F00F));
    send_command(make_cmd(MODE_BLIT, 8, 2, 1'b0, 4'hA, 1'b0, 1'b1, 1'b1,
                          64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
    // Origin just below the wrap: only the lower right of the sprite lands on screen.
    send_command(make_cmd(MODE_BLIT, 16'hFFFC, 16'hFFFE, 1'b1, 4'hF, 1'b1, 1'b1, 1'b1,
                          '1, '1));
    send_command(make_cmd(MODE_BLIT, 0, 0, 1'b0, 4'h0));
    send_command(make_cmd(MODE_READ, 3, 2));
    send_command(make_cmd(MODE_READ, 1, 1));
    send_command(make_cmd(MODE_NOP, 16'hFFFF, 16'hFFFF, 1'b1, 4'hF, 1'b1, 1'b1, 1'b1,
                          '1, '1));
    settle();
    // Zero width: nothing is inside the screen.
    program_screen(16'd0, 16'd8, 1'b0, '0, '0, '0);
    send_command(make_cmd(MODE_WRITE, 0, 0, 1'b1, 4'h1));
    send_command(make_cmd(MODE_READ, 0, 0));
    settle();
    // Oversized registers saturate; old contents are read under the new row length.
    program_screen(16'h03FF, 16'h03FF, 1'b0, '0, '0, '0);
    send_command(make_cmd(MODE_WRITE, 511, 511, 1'b0, 4'h3));
    send_command(make_cmd(MODE_READ, 511, 511));
    send_command(make_cmd(MODE_READ, 15, 0));
    settle();
  endtask

  // Random phases, each with its own screen, palette (where written) and idling profile:
  // none, sender idle, receiver stall, both lightly.
  task automatic run_random();
    bit [15:0]   widths  [PHASES] = '{16'd16, 16'd512, 16'd1, 16'h03FF,
                                      16'd37, 16'd8, 16'hFD2C, 16'd64};
    bit [15:0]   heights [PHASES] = '{16'd8, 16'd512, 16'd1, 16'h03FF,
                                      16'd21, 16'd200, 16'd3, 16'd64};
    bit [15:0]   lv;
    int unsigned ex;
    int unsigned ey;
    int unsigned p;
    int unsigned n;
    for (p = 0; p < PHASES; p++) begin
      idle_pct  = (p % 4 == 1) ? 80 : (p % 4 == 3) ? 12 : 0;
      stall_pct = (p % 4 == 2) ? 80 : (p % 4 == 3) ? 12 : 0;
      ex = (widths[p][9:0] > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : widths[p][9:0];
      ey = (heights[p][9:0] > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : heights[p][9:0];
      // Palette extremes on two phases, random levels elsewhere; two phases keep
      // the palette so size writes alone must not touch the changed flags.
      lv = (p == 3) ? 16'hFFFF : 16'h0000;
      if (p == 3 || p == 7)
        program_screen(widths[p], heights[p], 1'b1, lv, lv, lv);
      else
        program_screen(widths[p], heights[p], !(p == 2 || p == 5),
                       16'($urandom()), 16'($urandom()), 16'($urandom()));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the sender off mid-phase until the block has answered everything.
        if (n == ITEMS_PER_PHASE / 2) settle();
        send_command(random_cmd(ex, ey));
      end
      settle();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    shadow         = new();
    idle_pct       = 0;
    stall_pct      = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_WIDTH;
    cfg_data       = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    res_if.ready   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // The first item waits out the clearing pass; configuration is taken meanwhile.
    run_directed();
    run_random();
    settle();
    repeat (16) @(posedge clk);
    $display("run: %0d pixel writes, %0d sprite blits, %0d composite reads, %0d no-ops",
             mode_count[MODE_WRITE], mode_count[MODE_BLIT], mode_count[MODE_READ],
             mode_count[MODE_NOP]);
    $display("run: %0d results matched over %0d screen settings, %0d mismatches",
             shadow.replies_ok, settings_seen, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout with %0d results still owed", shadow.owed.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
